// File: sv/rnorm_pkg.sv
// shared types and codes for the fraction reduction block
package rnorm_pkg;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_ZERO_DEN = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

	// which division the shared divider runs
	typedef enum logic [1:0] {
		DIV_MOD,
		DIV_NUM,
		DIV_DEN
	} div_sel_t;

	// what kind of result gets written
	typedef enum logic [1:0] {
		RES_ZERO_DEN,
		RES_ZERO_NUM,
		RES_RATIO
	} res_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      load;
		logic      div_start;
		div_sel_t  div_sel;
		logic      gcd_step;
		logic      save_rn;
		logic      write;
		res_kind_t kind;
	} rnorm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic b_zero;
		logic div_idle;
		logic out_free;
	} rnorm_stat_t;

endpackage

// File: sv/rnorm_if.sv
// request and result channel interfaces
interface rnorm_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] num_in;
	logic signed [DATA_WIDTH-1:0] den_in;

	modport source(output valid, num_in, den_in, input ready);
	modport sink(input valid, num_in, den_in, output ready);
endinterface

interface rnorm_out_if import rnorm_pkg::*; #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] num_out;
	logic        [DATA_WIDTH-2:0] den_out;
	logic                         is_whole;
	status_t                      status;

	modport source(output valid, num_out, den_out, is_whole, status, input ready);
	modport sink(input valid, num_out, den_out, is_whole, status, output ready);
endinterface

// File: sv/rnorm_div.sv
// restoring divider, one quotient bit per cycle
module rnorm_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem,
	output logic         idle
);
	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quo_q;
	logic [W:0]       rem_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       rem_sh;
	logic [W:0]       diff;

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			// keep the difference when the shifted remainder covers the divisor
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q[W-1:0];
	assign idle = (cnt_q == '0);
endmodule

// File: sv/rnorm_dp.sv
// datapath: magnitudes, euclid registers, shared divider, result register
module rnorm_dp import rnorm_pkg::*; #(
	parameter int DW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rnorm_cmd_t           cmd,
	output rnorm_stat_t          stat,
	input  logic signed [DW-1:0] num_in,
	input  logic signed [DW-1:0] den_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [DW-1:0] num_out,
	output logic        [DW-2:0] den_out,
	output logic                 is_whole,
	output status_t              status
);
	logic [DW-1:0] nmag_q, dmag_q, a_q, b_q, rn_q;
	logic          nneg_q, dneg_q;
	logic [DW-1:0] div_a, div_b, quo, rem;
	logic          div_idle;
	logic          rneg, ovf;
	logic          out_valid_q;
	logic [DW-1:0] num_o_q;
	logic [DW-2:0] den_o_q;
	logic          whole_o_q;
	status_t       status_o_q;

	// operand select for the shared divider
	always_comb begin
		case (cmd.div_sel)
			DIV_MOD: begin div_a = a_q;    div_b = b_q; end
			DIV_NUM: begin div_a = nmag_q; div_b = a_q; end
			DIV_DEN: begin div_a = dmag_q; div_b = a_q; end
			default: begin div_a = a_q;    div_b = b_q; end
		endcase
	end

	rnorm_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quo      (quo),
		.rem      (rem),
		.idle     (div_idle)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nneg_q <= num_in[DW-1];
			dneg_q <= den_in[DW-1];
			nmag_q <= num_in[DW-1] ? DW'(0) - DW'(num_in) : DW'(num_in);
			dmag_q <= den_in[DW-1] ? DW'(0) - DW'(den_in) : DW'(den_in);
			a_q    <= num_in[DW-1] ? DW'(0) - DW'(num_in) : DW'(num_in);
			b_q    <= den_in[DW-1] ? DW'(0) - DW'(den_in) : DW'(den_in);
		end else if (cmd.gcd_step) begin
			a_q <= b_q;
			b_q <= rem;
		end
		if (cmd.save_rn) begin
			rn_q <= quo;
		end
	end

	// final check: quotient holds the reduced denominator here
	assign rneg = nneg_q ^ dneg_q;
	assign ovf  = quo[DW-1] | (rn_q[DW-1] & ~rneg);

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			case (cmd.kind)
				RES_ZERO_DEN: begin
					num_o_q    <= '0;
					den_o_q    <= '0;
					whole_o_q  <= 1'b0;
					status_o_q <= ST_ZERO_DEN;
				end
				RES_ZERO_NUM: begin
					num_o_q    <= '0;
					den_o_q    <= (DW-1)'(1);
					whole_o_q  <= 1'b1;
					status_o_q <= ST_OK;
				end
				RES_RATIO: begin
					if (ovf) begin
						num_o_q    <= '0;
						den_o_q    <= '0;
						whole_o_q  <= 1'b0;
						status_o_q <= ST_OVERFLOW;
					end else begin
						num_o_q    <= rneg ? DW'(0) - rn_q : rn_q;
						den_o_q    <= quo[DW-2:0];
						whole_o_q  <= (quo == DW'(1));
						status_o_q <= ST_OK;
					end
				end
				default: begin
					num_o_q    <= '0;
					den_o_q    <= '0;
					whole_o_q  <= 1'b0;
					status_o_q <= ST_ZERO_DEN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.den_zero = (dmag_q == '0);
	assign stat.num_zero = (nmag_q == '0);
	assign stat.b_zero   = (b_q == '0);
	assign stat.div_idle = div_idle;
	assign stat.out_free = ~out_valid_q | out_ready;

	assign out_valid = out_valid_q;
	assign num_out   = num_o_q;
	assign den_out   = den_o_q;
	assign is_whole  = whole_o_q;
	assign status    = status_o_q;
endmodule

// File: sv/rnorm_ctrl.sv
// controller: sequences euclid steps and the two final divisions
module rnorm_ctrl import rnorm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  rnorm_stat_t stat,
	output rnorm_cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_LOOP,
		S_MOD,
		S_RN,
		S_RD,
		S_DONE
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx      = state_q;
		cmd           = '0;
		cmd.div_sel   = DIV_MOD;
		cmd.kind      = RES_RATIO;
		in_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.den_zero || stat.num_zero) begin
					state_nx = S_DONE;
				end else begin
					state_nx = S_LOOP;
				end
			end
			S_LOOP: begin
				cmd.div_start = 1'b1;
				if (stat.b_zero) begin
					cmd.div_sel = DIV_NUM;
					state_nx    = S_RN;
				end else begin
					cmd.div_sel = DIV_MOD;
					state_nx    = S_MOD;
				end
			end
			S_MOD: begin
				if (stat.div_idle) begin
					cmd.gcd_step = 1'b1;
					state_nx     = S_LOOP;
				end
			end
			S_RN: begin
				cmd.div_sel = DIV_NUM;
				if (stat.div_idle) begin
					cmd.save_rn   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_DEN;
					state_nx      = S_RD;
				end
			end
			S_RD: begin
				cmd.div_sel = DIV_DEN;
				if (stat.div_idle) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.den_zero) begin
					cmd.kind = RES_ZERO_DEN;
				end else if (stat.num_zero) begin
					cmd.kind = RES_ZERO_NUM;
				end else begin
					cmd.kind = RES_RATIO;
				end
				if (stat.out_free) begin
					cmd.write = 1'b1;
					state_nx  = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end
endmodule

// File: sv/rational_normalize.sv
// top level: reduces a signed fraction to lowest terms
//
// usage
// - frac channel carries one request: num_in / den_in, two's complement
// - result channel returns one result per request: num_out (sign of the
//   fraction), den_out (positive), is_whole and a status code
// - status: ok, zero denominator, or overflow when the reduced result
//   needs +2^(DATA_WIDTH-1) in either part
// - timing: one request at a time; the result waits on the euclid remainder
//   steps and then the two final divisions, all run on the shared
//   one-bit-per-cycle divider; zero numerator or zero denominator results
//   skip the divider
// - throughput: the next request is taken the cycle after the write back,
//   so a new request waits until the previous one is written back
// - the result register parts the two sides: a new request is taken while
//   the previous result still waits; a stalled receiver only holds the
//   finished request in its last state until the register frees up
// - reset clears the controller and the result valid flag; no clearing pass
module rational_normalize import rnorm_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	rnorm_in_if.sink    frac,
	rnorm_out_if.source result
);
	rnorm_cmd_t  cmd;
	rnorm_stat_t stat;

	// sequencing of load, euclid loop, two divisions and write back
	rnorm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frac.valid),
		.in_ready (frac.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// operand registers, shared divider and result register
	rnorm_dp #(.DW(DATA_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.num_in    (frac.num_in),
		.den_in    (frac.den_in),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.num_out   (result.num_out),
		.den_out   (result.den_out),
		.is_whole  (result.is_whole),
		.status    (result.status)
	);

`ifndef ASSERT_OFF
	// one request in flight: ready drops right after a request is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		frac.valid && frac.ready |=> !frac.ready)
		else $error("request accepted while another is in flight");

	// a new result only appears after a write back command
	a_valid_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.write))
		else $error("result valid without write back");

	// an ok result always has a nonzero denominator
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == ST_OK |-> result.den_out != '0)
		else $error("ok result with zero denominator");

	// error results carry zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status == ST_OVERFLOW || result.status == ST_ZERO_DEN)
		|-> result.num_out == '0 && result.den_out == '0 && !result.is_whole)
		else $error("error result with nonzero payload");
`endif
endmodule

// File: dv/rational_normalize_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the fraction reduction block
module rational_normalize_test;
	import rnorm_pkg::*;

	localparam int DW = 32;
	localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

	// stimulus size and pacing
	localparam int RANDOM_REQUESTS = 1880;
	localparam int HOLD_AT_RESULT  = 40;     // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES     = 4000;   // long enough to fill the result register and stall input
	localparam int DRAIN_CYCLES    = 2000;   // beyond the slowest euclid run
	localparam int IDLE_LIMIT      = 20000;  // cycles without any handshake before giving up

	// one request: numerator and denominator as raw bits
	typedef struct packed {
		logic [DW-1:0] num;
		logic [DW-1:0] den;
	} fraction_t;

	// one reduced result, laid out like the result channel
	typedef struct packed {
		logic signed [DW-1:0] num;
		logic [DW-2:0]        den;
		logic                 whole;
		status_t              status;
	} reduced_t;

	logic clk = 1'b0;
	logic arst_n;

	rnorm_in_if  #(.DATA_WIDTH(DW)) frac_if ();
	rnorm_out_if #(.DATA_WIDTH(DW)) result_if ();

	rational_normalize #(.DATA_WIDTH(DW)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frac   (frac_if),
		.result (result_if)
	);

	always #6 clk = ~clk;

	fraction_t pending_q[$];     // requests not yet offered
	reduced_t  reduced_q[$];     // predicted results, oldest first

	int errors;
	int requests_taken;
	int results_seen;
	int ok_count, zero_den_count, overflow_count, whole_count;
	int gap_left, stall_left, hold_left;
	int input_stall_run, input_stall_max;
	bit hold_done;
	int idle_cycles;

	// --------------------------------------------------------------------
	// predictor: reduce on magnitudes, then put the sign on the numerator
	// --------------------------------------------------------------------
	function automatic reduced_t reduce_fraction(logic [DW-1:0] num, logic [DW-1:0] den);
		reduced_t      res;
		logic          num_neg, den_neg, res_neg;
		logic [DW-1:0] num_mag, den_mag, a, b, r, red_num, red_den;
		res     = '0;
		num_neg = num[DW-1];
		den_neg = den[DW-1];
		// negation of the most negative value leaves 2^(DW-1) as an unsigned magnitude
		num_mag = num_neg ? -num : num;
		den_mag = den_neg ? -den : den;
		if (den_mag == '0) begin
			res.status = ST_ZERO_DEN;
			return res;
		end
		if (num_mag == '0) begin
			res.den    = (DW-1)'(1);
			res.whole  = 1'b1;
			res.status = ST_OK;
			return res;
		end
		// euclid on the magnitudes
		a = num_mag;
		b = den_mag;
		while (b != '0) begin
			r = a % b;
			a = b;
			b = r;
		end
		red_num = num_mag / a;
		red_den = den_mag / a;
		res_neg = num_neg ^ den_neg;
		// +2^(DW-1) fits in neither part
		if (red_den >= MOST_NEG || (red_num >= MOST_NEG && !res_neg)) begin
			res.status = ST_OVERFLOW;
			return res;
		end
		res.num    = res_neg ? -red_num : red_num;
		res.den    = red_den[DW-2:0];
		res.whole  = (red_den == 1);
		res.status = ST_OK;
		return res;
	endfunction

	// gap length for either side: mostly none or short, now and then long,
	// and whole stretches with none at all
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(24, 4);
		return $urandom_range(400, 60);
	endfunction

	// corner values of a part: zero, unit, extremes, powers of two, small values and random words
	function automatic logic [DW-1:0] boundary_value();
		case ($urandom_range(9))
			0: return '0;
			1: return 1;
			2: return '1;
			3: return MOST_NEG;
			4: return MOST_POS;
			5: return MOST_NEG + 1;
			6: return 1 << $urandom_range(DW - 2);
			7: return -(1 << $urandom_range(DW - 2));
			8: return $urandom_range(9, 2);
			default: return $urandom;
		endcase
	endfunction

	// random request, weighted toward shared factors and corners
	function automatic fraction_t random_fraction();
		fraction_t     f;
		logic [DW-1:0] g, p, q;
		int            kind;
		kind = $urandom_range(99);
		if (kind < 35) begin
			// full range: exercises every bit, long euclid runs
			f.num = $urandom;
			f.den = $urandom;
		end else if (kind < 70) begin
			// common factor times short cofactors: real reduction, shorter runs
			g = $urandom_range(1 << 16, 1);
			p = $urandom_range(1 << 15, 0);
			q = $urandom_range(1 << 15, 1);
			f.num = $urandom_range(1) ? -(g * p) : g * p;
			f.den = $urandom_range(1) ? -(g * q) : g * q;
		end else if (kind < 85) begin
			// narrow values: many whole results and zero parts
			f.num = $urandom_range(2000) - 1000;
			f.den = $urandom_range(2000) - 1000;
		end else begin
			f.num = $urandom_range(3) == 0 ? $urandom : boundary_value();
			f.den = $urandom_range(3) == 0 ? $urandom : boundary_value();
		end
		return f;
	endfunction

	task automatic push_fraction(logic [DW-1:0] num, logic [DW-1:0] den);
		pending_q.push_back({num, den});
	endtask

	task automatic check_field(string name, logic signed [63:0] expv,
			logic signed [63:0] actv);
		if (actv !== expv) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
			errors++;
		end
	endtask

	// --------------------------------------------------------------------
	// request driver: offers queued requests, predicts on each handshake
	// --------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_if.valid  <= 1'b0;
			frac_if.num_in <= '0;
			frac_if.den_in <= '0;
			gap_left = 0;
		end else begin
			if (frac_if.valid && frac_if.ready) begin
				reduced_q.push_back(reduce_fraction(frac_if.num_in, frac_if.den_in));
				requests_taken++;
				input_stall_run = 0;
			end else if (frac_if.valid) begin
				// block busy: count how long the request waits
				input_stall_run++;
				if (input_stall_run > input_stall_max)
					input_stall_max = input_stall_run;
			end
			// the slot is free when nothing is offered or the offer was just taken
			if (!frac_if.valid || frac_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					frac_if.valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					fraction_t f;
					f = pending_q.pop_front();
					frac_if.num_in <= f.num;
					frac_if.den_in <= f.den;
					frac_if.valid  <= 1'b1;
					gap_left = pick_gap((requests_taken / 200) % 4 == 1);
				end else begin
					frac_if.valid <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// result monitor: checks each result against the oldest prediction
	// and drives ready with random stalls plus one long hold-off
	// --------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				results_seen++;
				if (reduced_q.size() == 0) begin
					$display("%0t: result with none expected, num %0d den %0d whole %0b status %0d",
						$time, result_if.num_out, result_if.den_out, result_if.is_whole,
						result_if.status);
					errors++;
				end else begin
					reduced_t exp_res;
					exp_res = reduced_q.pop_front();
					check_field("num_out", exp_res.num, result_if.num_out);
					check_field("den_out", exp_res.den, result_if.den_out);
					check_field("is_whole", exp_res.whole, result_if.is_whole);
					check_field("status", exp_res.status, result_if.status);
					case (exp_res.status)
						ST_OK:       ok_count++;
						ST_ZERO_DEN: zero_den_count++;
						ST_OVERFLOW: overflow_count++;
						default: ;
					endcase
					if (exp_res.whole)
						whole_count++;
				end
			end
			// one long hold-off so the block fills up and stalls its input
			if (!hold_done && results_seen == HOLD_AT_RESULT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else begin
				stall_left = pick_gap((results_seen / 150) % 5 == 2);
				result_if.ready <= (stall_left == 0);
			end
		end
	end

	// watchdog: a stuck handshake ends the run
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((frac_if.valid && frac_if.ready) || (result_if.valid && result_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results still due",
					$time, idle_cycles, reduced_q.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		// reset asserted right away; the driver and monitor clear their outputs
		arst_n = 1'b0;

		// directed: zero denominator
		push_fraction(0, 0);
		push_fraction(5, 0);
		push_fraction(MOST_NEG, 0);
		// zero numerator gives 0/1
		push_fraction(0, 5);
		push_fraction(0, -7);
		push_fraction(0, MOST_NEG);
		// most negative value where the result still fits
		push_fraction(MOST_NEG, 1);
		push_fraction(MOST_NEG, MOST_NEG);
		push_fraction(MOST_NEG, 3);
		push_fraction(MOST_NEG, MOST_POS);
		push_fraction(2, MOST_NEG);
		// overflow: reduced denominator or positive numerator reaches 2^(DW-1)
		push_fraction(MOST_NEG, -1);
		push_fraction(MOST_NEG, -3);
		push_fraction(1, MOST_NEG);
		push_fraction(MOST_POS, MOST_NEG);
		// signs, whole results and plain reduction
		push_fraction(MOST_POS, MOST_POS);
		push_fraction(MOST_POS, -1);
		push_fraction(-1, MOST_POS);
		push_fraction(6, -4);
		push_fraction(-6, 4);
		push_fraction(-6, -4);
		push_fraction(12, 3);
		push_fraction(1, 1);
		// consecutive fibonacci numbers: longest euclid run
		push_fraction(32'sd1836311903, 32'sd1134903170);

		repeat (RANDOM_REQUESTS)
			pending_q.push_back(random_fraction());

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all requests taken, then every prediction checked, then a quiet tail
		while (pending_q.size() != 0 || frac_if.valid)
			@(posedge clk);
		while (reduced_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d reduced, %0d zero denominator, %0d overflow",
			requests_taken, ok_count, zero_den_count, overflow_count);
		$display("%0d whole results; longest input stall %0d cycles; %0d mismatches",
			whole_count, input_stall_max, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
